// ===== hdl/ecpt_pkg.sv =====
`timescale 1ns / 1ps
package ecpt_pkg;

  // default sizes
  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS_DEF   = 16;
  localparam int CORNER_W         = 6;
  // operand bits taken per multiplier cycle
  localparam int MUL_CHUNK        = 16;
  localparam int STEP_W           = 5;

  typedef logic [STEP_W-1:0] step_t;

  // micro-program ranges
  localparam step_t STEP_CROSS_LO = 5'd0;
  localparam step_t STEP_CROSS_HI = 5'd1;
  localparam step_t STEP_SETUP_LO = 5'd2;
  localparam step_t STEP_SETUP_HI = 5'd12;
  localparam step_t STEP_POINT_LO = 5'd13;
  localparam step_t STEP_POINT_HI = 5'd22;

  // multiplier operand sources
  typedef enum logic [3:0] {
    OP_V0X, OP_V0Y, OP_V0Z, OP_V1X, OP_V1Y, OP_V1Z, OP_V2X, OP_V2Y, OP_V2Z,
    OP_E1X, OP_E1Y, OP_D00, OP_D01, OP_D02, OP_D11, OP_D12
  } op_t;

  // accumulator destinations
  typedef enum logic [3:0] {
    DST_NONE, DST_CR, DST_D00, DST_D01, DST_D02, DST_D11, DST_D12,
    DST_DEN, DST_UN, DST_VN
  } dst_t;

  typedef struct packed {
    op_t  src_a;
    op_t  src_b;
    logic sub;
    logic first;
    dst_t dest;
  } uop_t;

  typedef struct packed {
    logic  load_a;
    logic  load_b;
    logic  load_c;
    logic  load_p;
    logic  start;
    step_t step_first;
    step_t step_last;
  } geom_cmd_t;

  typedef struct packed {
    logic done;
    logic cr_pos;
    logic den_pos;
    logic enclosed;
  } geom_stat_t;

  typedef enum logic [4:0] {
    S_LOAD, S_START, S_PV0, S_PV1, S_PV2, S_FA, S_FB, S_FC, S_FD, S_OR, S_ORW,
    S_RV0, S_RV1, S_RV2, S_RV3, S_INIT, S_PASS, S_AL1, S_AL2, S_AL3, S_TRI,
    S_TRW, S_SUW, S_SC, S_SCD, S_SCW, S_EVAL, S_CLIP, S_SH, S_SHW, S_FINISH
  } ctrl_state_t;

  function automatic uop_t mk_uop(op_t a, op_t b, logic sub, logic first, dst_t dest);
    uop_t u;
    u.src_a = a;
    u.src_b = b;
    u.sub   = sub;
    u.first = first;
    u.dest  = dest;
    return u;
  endfunction

  // cross z, triangle setup (dots and gram determinant), per point numerators
  function automatic uop_t uop_at(step_t s);
    uop_t u;
    case (s)
      5'd0:    u = mk_uop(OP_V1X, OP_E1Y, 1'b0, 1'b1, DST_NONE);
      5'd1:    u = mk_uop(OP_V1Y, OP_E1X, 1'b1, 1'b0, DST_CR);
      5'd2:    u = mk_uop(OP_V0X, OP_V0X, 1'b0, 1'b1, DST_NONE);
      5'd3:    u = mk_uop(OP_V0Y, OP_V0Y, 1'b0, 1'b0, DST_NONE);
      5'd4:    u = mk_uop(OP_V0Z, OP_V0Z, 1'b0, 1'b0, DST_D00);
      5'd5:    u = mk_uop(OP_V0X, OP_V1X, 1'b0, 1'b1, DST_NONE);
      5'd6:    u = mk_uop(OP_V0Y, OP_V1Y, 1'b0, 1'b0, DST_NONE);
      5'd7:    u = mk_uop(OP_V0Z, OP_V1Z, 1'b0, 1'b0, DST_D01);
      5'd8:    u = mk_uop(OP_V1X, OP_V1X, 1'b0, 1'b1, DST_NONE);
      5'd9:    u = mk_uop(OP_V1Y, OP_V1Y, 1'b0, 1'b0, DST_NONE);
      5'd10:   u = mk_uop(OP_V1Z, OP_V1Z, 1'b0, 1'b0, DST_D11);
      5'd11:   u = mk_uop(OP_D00, OP_D11, 1'b0, 1'b1, DST_NONE);
      5'd12:   u = mk_uop(OP_D01, OP_D01, 1'b1, 1'b0, DST_DEN);
      5'd13:   u = mk_uop(OP_V0X, OP_V2X, 1'b0, 1'b1, DST_NONE);
      5'd14:   u = mk_uop(OP_V0Y, OP_V2Y, 1'b0, 1'b0, DST_NONE);
      5'd15:   u = mk_uop(OP_V0Z, OP_V2Z, 1'b0, 1'b0, DST_D02);
      5'd16:   u = mk_uop(OP_V1X, OP_V2X, 1'b0, 1'b1, DST_NONE);
      5'd17:   u = mk_uop(OP_V1Y, OP_V2Y, 1'b0, 1'b0, DST_NONE);
      5'd18:   u = mk_uop(OP_V1Z, OP_V2Z, 1'b0, 1'b0, DST_D12);
      5'd19:   u = mk_uop(OP_D11, OP_D02, 1'b0, 1'b1, DST_NONE);
      5'd20:   u = mk_uop(OP_D01, OP_D12, 1'b1, 1'b0, DST_UN);
      5'd21:   u = mk_uop(OP_D00, OP_D12, 1'b0, 1'b1, DST_NONE);
      5'd22:   u = mk_uop(OP_D01, OP_D02, 1'b1, 1'b0, DST_VN);
      default: u = mk_uop(OP_V0X, OP_V0X, 1'b0, 1'b1, DST_NONE);
    endcase
    return u;
  endfunction

endpackage

// ===== hdl/ecpt_ram.sv =====
`timescale 1ns / 1ps
module ecpt_ram #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/ecpt_mul.sv =====
`timescale 1ns / 1ps
module ecpt_mul #(
  parameter int MW = 36
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [MW-1:0] a,
  input  logic signed [MW-1:0] b,
  output logic                 done,
  output logic signed [2*MW-1:0] p
);
  import ecpt_pkg::*;

  localparam int CH  = MUL_CHUNK;
  localparam int NC  = (MW + CH - 1) / CH;
  localparam int PW  = NC * CH;
  localparam int NCW = $clog2(NC + 1);

  logic [MW-1:0]   ma_r;
  logic [PW-1:0]   mb_r;
  logic            neg_r;
  logic [2*MW-1:0] acc_r;
  logic [NCW-1:0]  left_r;
  logic            run_r;
  logic            done_r;
  logic [MW-1:0]   a_mag;
  logic [MW-1:0]   b_mag;
  logic [MW+CH-1:0] part;

  assign a_mag = a[MW-1] ? (~a + 1'b1) : a;
  assign b_mag = b[MW-1] ? (~b + 1'b1) : b;
  // one chunk of the multiplier per cycle, top chunk first
  assign part  = ma_r * mb_r[PW-1 -: CH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      left_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        left_r <= NCW'(NC);
      end else if (run_r) begin
        left_r <= left_r - 1'b1;
        if (left_r == NCW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // horner accumulation of partial products
  always_ff @(posedge clk) begin
    if (start) begin
      ma_r  <= a_mag;
      mb_r  <= PW'(b_mag);
      neg_r <= a[MW-1] ^ b[MW-1];
      acc_r <= '0;
    end else if (run_r) begin
      acc_r <= (acc_r << CH) + (2*MW)'(part);
      mb_r  <= mb_r << CH;
    end
  end

  assign done = done_r;
  assign p    = neg_r ? -$signed(acc_r) : $signed(acc_r);

endmodule

// ===== hdl/ecpt_geom.sv =====
`timescale 1ns / 1ps
module ecpt_geom #(
  parameter int COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ecpt_pkg::geom_cmd_t       cmd,
  input  logic [3*COORD_BITS-1:0]   vtx,
  output ecpt_pkg::geom_stat_t      stat
);
  import ecpt_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int DIF = CB + 1;
  localparam int DW  = 2 * DIF + 2;
  localparam int AW  = 2 * DW + 2;

  logic [3*CB-1:0] va_r, vb_r, vc_r, vp_r;
  logic signed [CB-1:0]  ca [3];
  logic signed [CB-1:0]  cb [3];
  logic signed [CB-1:0]  cc [3];
  logic signed [CB-1:0]  cp [3];
  logic signed [DIF-1:0] v0 [3];
  logic signed [DIF-1:0] v1 [3];
  logic signed [DIF-1:0] v2 [3];
  logic signed [DIF-1:0] e1x, e1y;

  logic signed [DW-1:0] d00_r, d01_r, d02_r, d11_r, d12_r;
  logic signed [AW-1:0] den_r, un_r, vn_r, acc_r;
  logic                 cr_pos_r;

  step_t step_r, last_r;
  logic  run_r, go_r, done_r;
  uop_t  u;

  logic signed [DW-1:0]   opa, opb;
  logic                   mdone;
  logic signed [2*DW-1:0] prod;
  logic signed [AW-1:0]   pext, acc_nxt;
  logic signed [AW-1:0]   uv_sum;

  // vertex operand registers
  always_ff @(posedge clk) begin
    if (cmd.load_a) va_r <= vtx;
    if (cmd.load_b) vb_r <= vtx;
    if (cmd.load_c) vc_r <= vtx;
    if (cmd.load_p) vp_r <= vtx;
  end

  // edge vectors
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ca[k] = va_r[k*CB +: CB];
      cb[k] = vb_r[k*CB +: CB];
      cc[k] = vc_r[k*CB +: CB];
      cp[k] = vp_r[k*CB +: CB];
      v0[k] = DIF'(cc[k]) - DIF'(ca[k]);
      v1[k] = DIF'(cb[k]) - DIF'(ca[k]);
      v2[k] = DIF'(cp[k]) - DIF'(ca[k]);
    end
    e1x = DIF'(cc[0]) - DIF'(cb[0]);
    e1y = DIF'(cc[1]) - DIF'(cb[1]);
  end

  assign u = uop_at(step_r);

  function automatic logic signed [DW-1:0] pick(
    op_t o, logic signed [DIF-1:0] a0 [3], logic signed [DIF-1:0] a1 [3],
    logic signed [DIF-1:0] a2 [3], logic signed [DIF-1:0] ex,
    logic signed [DIF-1:0] ey, logic signed [DW-1:0] q00,
    logic signed [DW-1:0] q01, logic signed [DW-1:0] q02,
    logic signed [DW-1:0] q11, logic signed [DW-1:0] q12);
    logic signed [DW-1:0] r;
    unique case (o)
      OP_V0X: r = DW'(a0[0]);
      OP_V0Y: r = DW'(a0[1]);
      OP_V0Z: r = DW'(a0[2]);
      OP_V1X: r = DW'(a1[0]);
      OP_V1Y: r = DW'(a1[1]);
      OP_V1Z: r = DW'(a1[2]);
      OP_V2X: r = DW'(a2[0]);
      OP_V2Y: r = DW'(a2[1]);
      OP_V2Z: r = DW'(a2[2]);
      OP_E1X: r = DW'(ex);
      OP_E1Y: r = DW'(ey);
      OP_D00: r = q00;
      OP_D01: r = q01;
      OP_D02: r = q02;
      OP_D11: r = q11;
      OP_D12: r = q12;
    endcase
    return r;
  endfunction

  assign opa = pick(u.src_a, v0, v1, v2, e1x, e1y, d00_r, d01_r, d02_r, d11_r, d12_r);
  assign opb = pick(u.src_b, v0, v1, v2, e1x, e1y, d00_r, d01_r, d02_r, d11_r, d12_r);

  ecpt_mul #(.MW(DW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r),
    .a     (opa),
    .b     (opb),
    .done  (mdone),
    .p     (prod)
  );

  // accumulate signed products
  assign pext    = AW'(prod);
  assign acc_nxt = (u.first ? AW'(0) : acc_r) + (u.sub ? -pext : pext);

  // micro-program sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      go_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      go_r   <= 1'b0;
      done_r <= 1'b0;
      if (cmd.start) begin
        step_r <= cmd.step_first;
        last_r <= cmd.step_last;
        run_r  <= 1'b1;
        go_r   <= 1'b1;
      end else if (run_r && mdone) begin
        if (step_r == last_r) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 1'b1;
          go_r   <= 1'b1;
        end
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (run_r && mdone) begin
      acc_r <= acc_nxt;
      unique case (u.dest)
        DST_NONE: ;
        DST_CR:   cr_pos_r <= !acc_nxt[AW-1] && (acc_nxt != '0);
        DST_D00:  d00_r <= acc_nxt[DW-1:0];
        DST_D01:  d01_r <= acc_nxt[DW-1:0];
        DST_D02:  d02_r <= acc_nxt[DW-1:0];
        DST_D11:  d11_r <= acc_nxt[DW-1:0];
        DST_D12:  d12_r <= acc_nxt[DW-1:0];
        DST_DEN:  den_r <= acc_nxt;
        DST_UN:   un_r  <= acc_nxt;
        DST_VN:   vn_r  <= acc_nxt;
        default:  ;
      endcase
    end
  end

  // inclusive barycentric test against the gram determinant
  assign uv_sum        = un_r + vn_r;
  assign stat.done     = done_r;
  assign stat.cr_pos   = cr_pos_r;
  assign stat.den_pos  = !den_r[AW-1] && (den_r != '0);
  assign stat.enclosed = stat.den_pos && !un_r[AW-1] && (un_r <= den_r)
                         && !vn_r[AW-1] && (vn_r <= den_r) && (uv_sum <= den_r);

endmodule

// ===== hdl/ear_clip_polygon_triangulator_top.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake           | word
// in_     | input     | in_valid / in_stall | one vertex (x, y, z, final flag)
// out_    | output    | out_valid/out_stall | one triangle or the empty result
//
// Vertices load at one per cycle. After the final vertex the block stalls input while
// it triangulates: a pivot scan, a swap of vertex pairs if the order is reversed, the
// active list setup, then per triple the list reads, the vertex fetches and the
// cross product (2 products), plus 11 products for setup and 10 per tested point; each
// product runs on the one shared multiplier.
// Reset is synchronous, active low. A finished result waits in the output register
// while the next polygon loads.
module ear_clip_polygon_triangulator_top #(
  parameter int MAX_VERTICES = ecpt_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = ecpt_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [COORD_BITS-1:0]       in_vert_x,
  input  logic signed [COORD_BITS-1:0]       in_vert_y,
  input  logic signed [COORD_BITS-1:0]       in_vert_z,
  input  logic                               in_final_vertex,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ecpt_pkg::CORNER_W-1:0]      out_corner_far,
  output logic [ecpt_pkg::CORNER_W-1:0]      out_corner_mid,
  output logic [ecpt_pkg::CORNER_W-1:0]      out_corner_near,
  output logic                               out_order_reversed,
  output logic                               out_no_triangle,
  output logic                               out_vertices_dropped,
  output logic                               out_final_triangle
);
  import ecpt_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int IW   = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int VW   = 3 * CB;

  ctrl_state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt, n_r, n_nxt, m_r, m_nxt;
  logic [CNTW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic            ovf_r, ovf_nxt, drop_r, drop_nxt, rev_r, rev_nxt, busy_r, busy_nxt;
  logic [IW-1:0]   piv_r, piv_nxt, a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic signed [CB-1:0] pivx_r, pivx_nxt;
  logic [VW-1:0]   tmp_r, tmp_nxt;
  logic            pend_v_r, pend_v_nxt;
  logic [IW-1:0]   pf_r, pf_nxt, pm_r, pm_nxt, pn_r, pn_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [CORNER_W-1:0] of_r, of_nxt, om_r, om_nxt, on_r, on_nxt;
  logic                orev_r, orev_nxt, onone_r, onone_nxt;
  logic                odrop_r, odrop_nxt, ofin_r, ofin_nxt;

  logic            vs_we, al_we;
  logic [IW-1:0]   vs_waddr, vs_raddr, al_waddr, al_raddr, al_wdata, al_rdata;
  logic [VW-1:0]   vs_wdata, vs_rdata;
  geom_cmd_t       gcmd;
  geom_stat_t      gst;

  logic            in_acc, out_free;
  logic signed [CB-1:0] rd_x, rd_y;
  logic [CNTW:0]   i_ext, k_ext, m_ext;
  logic [CNTW-1:0] half;

  ecpt_ram #(.W(VW), .D(MAX_VERTICES)) u_vstore (
    .clk (clk), .we (vs_we), .waddr (vs_waddr), .wdata (vs_wdata),
    .raddr (vs_raddr), .rdata (vs_rdata)
  );

  ecpt_ram #(.W(IW), .D(MAX_VERTICES)) u_alist (
    .clk (clk), .we (al_we), .waddr (al_waddr), .wdata (al_wdata),
    .raddr (al_raddr), .rdata (al_rdata)
  );

  ecpt_geom #(.COORD_BITS(CB)) u_geom (
    .clk (clk), .rst_n (rst_n), .cmd (gcmd), .vtx (vs_rdata), .stat (gst)
  );

  assign in_stall = (state_r != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign rd_x     = vs_rdata[CB-1:0];
  assign rd_y     = vs_rdata[2*CB-1:CB];
  assign i_ext    = {1'b0, i_r};
  assign k_ext    = {1'b0, k_r};
  assign m_ext    = {1'b0, m_r};
  assign half     = n_r >> 1;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and output word registers
  always_ff @(posedge clk) begin
    ret_r   <= ret_nxt;
    n_r     <= n_nxt;
    m_r     <= m_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    drop_r  <= drop_nxt;
    rev_r   <= rev_nxt;
    busy_r  <= busy_nxt;
    piv_r   <= piv_nxt;
    pivx_r  <= pivx_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    c_r     <= c_nxt;
    tmp_r   <= tmp_nxt;
    pf_r    <= pf_nxt;
    pm_r    <= pm_nxt;
    pn_r    <= pn_nxt;
    of_r    <= of_nxt;
    om_r    <= om_nxt;
    on_r    <= on_nxt;
    orev_r  <= orev_nxt;
    onone_r <= onone_nxt;
    odrop_r <= odrop_nxt;
    ofin_r  <= ofin_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    n_nxt     = n_r;
    m_nxt     = m_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    drop_nxt  = drop_r;
    rev_nxt   = rev_r;
    busy_nxt  = busy_r;
    piv_nxt   = piv_r;
    pivx_nxt  = pivx_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    tmp_nxt   = tmp_r;
    pend_v_nxt = pend_v_r;
    pf_nxt    = pf_r;
    pm_nxt    = pm_r;
    pn_nxt    = pn_r;

    out_valid_nxt = out_valid_r && out_stall;
    of_nxt    = of_r;
    om_nxt    = om_r;
    on_nxt    = on_r;
    orev_nxt  = orev_r;
    onone_nxt = onone_r;
    odrop_nxt = odrop_r;
    ofin_nxt  = ofin_r;

    vs_we    = 1'b0;
    vs_waddr = cnt_r[IW-1:0];
    vs_wdata = {in_vert_z, in_vert_y, in_vert_x};
    vs_raddr = i_r[IW-1:0];
    al_we    = 1'b0;
    al_waddr = i_r[IW-1:0];
    al_wdata = i_r[IW-1:0];
    al_raddr = i_r[IW-1:0];
    gcmd     = '0;

    unique case (state_r)
      // vertex loading
      S_LOAD: begin
        if (in_acc) begin
          if (cnt_r < CNTW'(MAX_VERTICES)) begin
            vs_we   = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_final_vertex) begin
            n_nxt     = cnt_nxt;
            drop_nxt  = ovf_nxt;
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        rev_nxt = 1'b0;
        i_nxt   = '0;
        piv_nxt = '0;
        if (n_r < CNTW'(3)) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_PV0;
        end
      end
      // pivot search
      S_PV0: begin
        vs_raddr  = i_r[IW-1:0];
        state_nxt = S_PV1;
      end
      S_PV1: begin
        if (i_r == '0) begin
          pivx_nxt = rd_x;
        end else if (rd_x != '0 && rd_y != '0 && rd_x > pivx_r) begin
          piv_nxt  = i_r[IW-1:0];
          pivx_nxt = rd_x;
        end
        i_nxt = i_r + 1'b1;
        if (i_r + 1'b1 == n_r) begin
          state_nxt = S_PV2;
        end else begin
          state_nxt = S_PV0;
        end
      end
      S_PV2: begin
        a_nxt     = (piv_r == '0) ? IW'(n_r - 1'b1) : piv_r - 1'b1;
        b_nxt     = piv_r;
        c_nxt     = (CNTW'(piv_r) == n_r - 1'b1) ? '0 : piv_r + 1'b1;
        ret_nxt   = S_OR;
        state_nxt = S_FA;
      end
      // fetch vertices a, b and c into the datapath
      S_FA: begin
        vs_raddr  = a_r;
        state_nxt = S_FB;
      end
      S_FB: begin
        vs_raddr    = b_r;
        gcmd.load_a = 1'b1;
        state_nxt   = S_FC;
      end
      S_FC: begin
        vs_raddr    = c_r;
        gcmd.load_b = 1'b1;
        state_nxt   = S_FD;
      end
      S_FD: begin
        gcmd.load_c = 1'b1;
        state_nxt   = ret_r;
      end
      // orientation
      S_OR: begin
        gcmd.start      = 1'b1;
        gcmd.step_first = STEP_CROSS_LO;
        gcmd.step_last  = STEP_CROSS_HI;
        state_nxt       = S_ORW;
      end
      S_ORW: begin
        if (gst.done) begin
          i_nxt = '0;
          if (gst.cr_pos) begin
            rev_nxt   = 1'b1;
            state_nxt = S_RV0;
          end else begin
            state_nxt = S_INIT;
          end
        end
      end
      // store reversal, one pair swapped per pass through S_RV0 to S_RV3
      S_RV0: begin
        vs_raddr  = i_r[IW-1:0];
        state_nxt = S_RV1;
      end
      S_RV1: begin
        vs_raddr  = IW'(n_r - 1'b1 - i_r);
        tmp_nxt   = vs_rdata;
        state_nxt = S_RV2;
      end
      S_RV2: begin
        vs_we     = 1'b1;
        vs_waddr  = i_r[IW-1:0];
        vs_wdata  = vs_rdata;
        state_nxt = S_RV3;
      end
      S_RV3: begin
        vs_we    = 1'b1;
        vs_waddr = IW'(n_r - 1'b1 - i_r);
        vs_wdata = tmp_r;
        i_nxt    = i_r + 1'b1;
        if (i_r + 1'b1 == half) begin
          i_nxt     = '0;
          state_nxt = S_INIT;
        end else begin
          state_nxt = S_RV0;
        end
      end
      // active list set to identity
      S_INIT: begin
        al_we    = 1'b1;
        al_waddr = i_r[IW-1:0];
        al_wdata = i_r[IW-1:0];
        i_nxt    = i_r + 1'b1;
        if (i_r + 1'b1 == n_r) begin
          i_nxt     = '0;
          m_nxt     = n_r;
          busy_nxt  = 1'b0;
          state_nxt = S_PASS;
        end
      end
      // pass over consecutive triples
      S_PASS: begin
        if (i_ext + 2'd2 < m_ext) begin
          al_raddr  = i_r[IW-1:0];
          state_nxt = S_AL1;
        end else if (busy_r) begin
          i_nxt    = '0;
          busy_nxt = 1'b0;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_AL1: begin
        a_nxt     = al_rdata;
        al_raddr  = IW'(i_r + 1'b1);
        state_nxt = S_AL2;
      end
      S_AL2: begin
        b_nxt     = al_rdata;
        al_raddr  = IW'(i_ext + 2'd2);
        state_nxt = S_AL3;
      end
      S_AL3: begin
        c_nxt     = al_rdata;
        ret_nxt   = S_TRI;
        state_nxt = S_FA;
      end
      S_TRI: begin
        gcmd.start      = 1'b1;
        gcmd.step_first = STEP_CROSS_LO;
        gcmd.step_last  = STEP_CROSS_HI;
        state_nxt       = S_TRW;
      end
      S_TRW: begin
        if (gst.done) begin
          if (gst.cr_pos) begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_PASS;
          end else begin
            gcmd.start      = 1'b1;
            gcmd.step_first = STEP_SETUP_LO;
            gcmd.step_last  = STEP_SETUP_HI;
            state_nxt       = S_SUW;
          end
        end
      end
      S_SUW: begin
        if (gst.done) begin
          j_nxt = '0;
          if (gst.den_pos) begin
            state_nxt = S_SC;
          end else begin
            state_nxt = S_CLIP;
          end
        end
      end
      // containment scan over the other stored vertices
      S_SC: begin
        if (j_r == n_r) begin
          state_nxt = S_CLIP;
        end else if (j_r == CNTW'(a_r) || j_r == CNTW'(b_r) || j_r == CNTW'(c_r)) begin
          j_nxt = j_r + 1'b1;
        end else begin
          vs_raddr  = j_r[IW-1:0];
          state_nxt = S_SCD;
        end
      end
      S_SCD: begin
        gcmd.load_p     = 1'b1;
        gcmd.start      = 1'b1;
        gcmd.step_first = STEP_POINT_LO;
        gcmd.step_last  = STEP_POINT_HI;
        state_nxt       = S_SCW;
      end
      S_SCW: begin
        if (gst.done) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (gst.enclosed) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_PASS;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_SC;
        end
      end
      // clip: the previous triangle goes out, the new one is held back
      S_CLIP: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            of_nxt        = CORNER_W'(pf_r);
            om_nxt        = CORNER_W'(pm_r);
            on_nxt        = CORNER_W'(pn_r);
            orev_nxt      = rev_r;
            onone_nxt     = 1'b0;
            odrop_nxt     = drop_r;
            ofin_nxt      = 1'b0;
          end
          pend_v_nxt = 1'b1;
          pf_nxt     = c_r;
          pm_nxt     = b_r;
          pn_nxt     = a_r;
          k_nxt      = i_r + 1'b1;
          state_nxt  = S_SH;
        end
      end
      // close the gap in the active list
      S_SH: begin
        if (k_ext + 1'b1 < m_ext) begin
          al_raddr  = IW'(k_r + 1'b1);
          state_nxt = S_SHW;
        end else begin
          m_nxt     = m_r - 1'b1;
          busy_nxt  = 1'b1;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_PASS;
        end
      end
      S_SHW: begin
        al_we     = 1'b1;
        al_waddr  = k_r[IW-1:0];
        al_wdata  = al_rdata;
        k_nxt     = k_r + 1'b1;
        state_nxt = S_SH;
      end
      // last word of the polygon
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          orev_nxt      = rev_r;
          odrop_nxt     = drop_r;
          ofin_nxt      = 1'b1;
          if (pend_v_r) begin
            of_nxt    = CORNER_W'(pf_r);
            om_nxt    = CORNER_W'(pm_r);
            on_nxt    = CORNER_W'(pn_r);
            onone_nxt = 1'b0;
          end else begin
            of_nxt    = '0;
            om_nxt    = '0;
            on_nxt    = '0;
            onone_nxt = 1'b1;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  assign out_valid            = out_valid_r;
  assign out_corner_far       = of_r;
  assign out_corner_mid       = om_r;
  assign out_corner_near      = on_r;
  assign out_order_reversed   = orev_r;
  assign out_no_triangle      = onone_r;
  assign out_vertices_dropped = odrop_r;
  assign out_final_triangle   = ofin_r;

endmodule
